/* hdl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the periodic timer table: field widths,
// action codes, result kinds, controller states and the slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

   // table geometry and field widths
   localparam int SLOTS   = 16;
   localparam int SLOT_W  = 4;
   localparam int CNT_W   = 5;
   localparam int TIME_W  = 64;
   localparam int ACT_W   = 2;
   localparam int KIND_W  = 3;

   // packed beat widths
   localparam int REQ_TDATA_W = 2 * TIME_W;
   localparam int RSP_FIELD_W = SLOT_W + CNT_W + TIME_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // fire limit after reset
   localparam logic [CNT_W-1:0] FIRE_LIMIT_RST = CNT_W'(16);

   // action codes on the request side
   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED = 3'd0,
      KIND_ZERO  = 3'd1,
      KIND_FULL  = 3'd2,
      KIND_FIRED = 3'd3,
      KIND_DONE  = 3'd4,
      KIND_LEFT  = 3'd5
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one slot of the timer memory
   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] deadline;
   } entry_type;

endpackage

`default_nettype wire

/* hdl/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers held in a slot memory, with add, tick and query
// requests and a stream of result beats.
// ----------------------------------------------------------------------------
// An add request goes from ST_IDLE to ST_ADD, which registers its result beat
// once the output register is free. A tick or query request goes through
// ST_SCAN and ST_FINISH: the controller walks the slot memory through its single
// read port, one slot per cycle while not stalled, evaluating each slot the cycle
// after its read and writing an advanced deadline straight back. A fired beat
// that meets a full output register holds the walk until it is taken. One
// request is in work at a time; the next is accepted once the final beat of
// the current one is registered. Period and deadline memory is not cleared
// after reset; a slot's entry is only looked at while its used bit is set.
`default_nettype none

module periodic_timer_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration: fire limit
   input  wire logic                              csr_wen,
   input  wire logic [ptt_pkg::CNT_W-1:0]         csr_wdata,
   // request channel
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [ptt_pkg::REQ_TDATA_W-1:0]   req_tdata,  // interval, now
   input  wire logic [ptt_pkg::ACT_W-1:0]         req_tuser,  // action
   // result channel
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ptt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // slot, count, time_left
   output      logic [ptt_pkg::KIND_W-1:0]        rsp_tuser,  // kind
   output      logic                              rsp_tlast
);

   localparam int SLOTS  = ptt_pkg::SLOTS;
   localparam int SLOT_W = ptt_pkg::SLOT_W;
   localparam int CNT_W  = ptt_pkg::CNT_W;
   localparam int TIME_W = ptt_pkg::TIME_W;
   localparam int ACT_W  = ptt_pkg::ACT_W;

   // control state
   ptt_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]      fire_limit_ff, fire_limit_in;
   logic [SLOTS-1:0]      used_ff, used_in;
   logic [SLOT_W:0]       rd_idx_ff, rd_idx_in;
   logic                  ev_vld_ff, ev_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request payload and scan results
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [TIME_W-1:0]     interval_ff, interval_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [SLOT_W-1:0]     ev_idx_ff, ev_idx_in;
   logic [CNT_W-1:0]      fired_ff, fired_in;
   logic                  hit_ff, hit_in;
   logic                  found_ff, found_in;
   logic [TIME_W-1:0]     best_ff, best_in;

   // output register payload
   ptt_pkg::kind_type     rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [TIME_W-1:0]     rsp_left_ff, rsp_left_in;
   logic                  rsp_last_ff, rsp_last_in;

   // slot memory
   ptt_pkg::entry_type    slot_mem [SLOTS];
   ptt_pkg::entry_type    rd_data_ff;
   logic                  rd_en;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   ptt_pkg::entry_type    mem_wdata;

   // helpers
   logic                  out_free;
   logic                  is_tick;
   logic                  free_any;
   logic [SLOT_W-1:0]     free_idx;
   logic                  ev_used;
   logic                  tick_due;
   logic [TIME_W-1:0]     adv_sum;
   logic [TIME_W-1:0]     now_sum;
   logic [TIME_W-1:0]     new_deadline;
   logic [TIME_W:0]       q_sub;
   logic                  q_le;
   logic                  stall;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_tick  = (act_ff == ptt_pkg::ACT_TICK);

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // evaluation of the slot read in the previous cycle
   assign ev_used      = used_ff[ev_idx_ff];
   assign tick_due     = ev_used && (now_ff >= rd_data_ff.deadline) &&
                         (fired_ff < fire_limit_ff);
   assign adv_sum      = rd_data_ff.deadline + rd_data_ff.period;
   assign now_sum      = now_ff + rd_data_ff.period;
   assign new_deadline = (adv_sum <= now_ff) ? now_sum : adv_sum;
   assign q_sub        = {1'b0, rd_data_ff.deadline} - {1'b0, now_ff};
   assign q_le         = q_sub[TIME_W] || (q_sub[TIME_W-1:0] == '0);
   assign stall        = ev_vld_ff && is_tick && tick_due && !out_free;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      fire_limit_in = fire_limit_ff;
      used_in       = used_ff;
      rd_idx_in     = rd_idx_ff;
      ev_vld_in     = ev_vld_ff;
      ev_idx_in     = ev_idx_ff;
      act_in        = act_ff;
      interval_in   = interval_ff;
      now_in        = now_ff;
      fired_in      = fired_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = free_idx;
      mem_wdata     = '{period: interval_ff, deadline: interval_ff};
      req_tready    = 1'b0;

      if (csr_wen) begin
         fire_limit_in = csr_wdata;
      end

      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in      = req_tuser;
               interval_in = req_tdata[TIME_W-1:0];
               now_in      = req_tdata[2*TIME_W-1:TIME_W];
               rd_idx_in   = '0;
               ev_vld_in   = 1'b0;
               fired_in    = '0;
               hit_in      = 1'b0;
               found_in    = 1'b0;
               best_in     = '0;
               priority if (req_tuser == ptt_pkg::ACT_ADD) begin
                  state_in = ptt_pkg::ST_ADD;
               end else if (req_tuser == ptt_pkg::ACT_TICK ||
                            req_tuser == ptt_pkg::ACT_QUERY) begin
                  state_in = ptt_pkg::ST_SCAN;
               end else begin
                  state_in = ptt_pkg::ST_IDLE;
               end
            end
         end

         // claim the lowest free slot, or report a zero interval or a full table
         ptt_pkg::ST_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_count_in = '0;
               rsp_left_in  = '0;
               rsp_last_in  = 1'b1;
               priority if (interval_ff == '0) begin
                  rsp_kind_in = ptt_pkg::KIND_ZERO;
               end else if (!free_any) begin
                  rsp_kind_in = ptt_pkg::KIND_FULL;
               end else begin
                  rsp_kind_in       = ptt_pkg::KIND_ADDED;
                  rsp_slot_in       = free_idx;
                  mem_we            = 1'b1;
                  used_in[free_idx] = 1'b1;
               end
               state_in = ptt_pkg::ST_IDLE;
            end
         end

         // walk the slots, one read and one evaluation per cycle unless stalled
         ptt_pkg::ST_SCAN: begin
            if (!stall) begin
               if (ev_vld_ff) begin
                  if (is_tick) begin
                     if (tick_due) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = ptt_pkg::KIND_FIRED;
                        rsp_slot_in  = ev_idx_ff;
                        rsp_count_in = '0;
                        rsp_left_in  = '0;
                        rsp_last_in  = 1'b0;
                        mem_we       = 1'b1;
                        mem_waddr    = ev_idx_ff;
                        mem_wdata    = '{period: rd_data_ff.period,
                                         deadline: new_deadline};
                        fired_in     = fired_ff + CNT_W'(1);
                     end
                  end else if (ev_used) begin
                     if (q_le) begin
                        hit_in = 1'b1;
                     end else if (!found_ff || q_sub[TIME_W-1:0] < best_ff) begin
                        best_in  = q_sub[TIME_W-1:0];
                        found_in = 1'b1;
                     end
                  end
               end
               rd_en     = (rd_idx_ff < (SLOT_W+1)'(SLOTS));
               ev_vld_in = rd_en;
               ev_idx_in = rd_idx_ff[SLOT_W-1:0];
               if (rd_en) begin
                  rd_idx_in = rd_idx_ff + (SLOT_W+1)'(1);
               end else begin
                  state_in = ptt_pkg::ST_FINISH;
               end
            end
         end

         // closing beat of a tick or query
         ptt_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               if (is_tick) begin
                  rsp_kind_in  = ptt_pkg::KIND_DONE;
                  rsp_count_in = fired_ff;
                  rsp_left_in  = '0;
               end else begin
                  rsp_kind_in  = ptt_pkg::KIND_LEFT;
                  rsp_count_in = '0;
                  rsp_left_in  = hit_ff ? '0 : best_ff;
               end
               state_in = ptt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptt_pkg::ST_IDLE;
         fire_limit_ff <= ptt_pkg::FIRE_LIMIT_RST;
         used_ff       <= '0;
         rd_idx_ff     <= '0;
         ev_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fire_limit_ff <= fire_limit_in;
         used_ff       <= used_in;
         rd_idx_ff     <= rd_idx_in;
         ev_vld_ff     <= ev_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      interval_ff  <= interval_in;
      now_ff       <= now_in;
      ev_idx_ff    <= ev_idx_in;
      fired_ff     <= fired_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_idx_ff[SLOT_W-1:0]];
      end
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{ptt_pkg::RSP_PAD_W{1'b0}}, rsp_left_ff, rsp_count_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
